// File: hw/rtl/ptla_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ptla_pkg;

  // Register indexes on the configuration port.
  localparam int unsigned CFG_INDEX_BITS = 2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_MID_LEVEL  = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_TOP_LEVEL  = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_BAND_WIDTH = 2'd2;

  // Depth of the job queue between the front and the divider.
  localparam int unsigned QUEUE_DEPTH = 4;

  // Occupancy flags of the job queue, seen by both of its neighbours.
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

`default_nettype wire

// File: hw/rtl/ptla_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module ptla_queue #(
  parameter int unsigned WIDTH = 160,
  parameter int unsigned DEPTH = 4
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  logic [WIDTH-1:0]    push_data,
  input  logic                pop,
  output logic [WIDTH-1:0]    pop_data,
  output ptla_pkg::q_status_t status
);

  localparam int unsigned PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_BITS = $clog2(DEPTH + 1);

  logic [WIDTH-1:0]    entries [DEPTH];
  logic [PTR_BITS-1:0] wr_ptr;
  logic [PTR_BITS-1:0] rd_ptr;
  logic [CNT_BITS-1:0] fill;

  always_comb begin
    status.full  = (fill == CNT_BITS'(DEPTH));
    status.empty = (fill == '0);
    pop_data     = entries[rd_ptr];
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/ptla_front.sv
`timescale 1ns / 1ps
`default_nettype none

module ptla_front #(
  parameter int unsigned SAMPLE_BITS = 16,
  parameter int unsigned TIME_BITS   = 48,
  parameter int unsigned COUNT_BITS  = 24,
  parameter int unsigned JOB_BITS    = 2 * TIME_BITS + SAMPLE_BITS + 2 * COUNT_BITS
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_wr_en,
  input  logic [ptla_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [SAMPLE_BITS-1:0]              cfg_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [SAMPLE_BITS-1:0]       sample_value,
  input  logic [TIME_BITS-1:0]                sample_time,
  input  ptla_pkg::q_status_t                 q_status,
  output logic                                push,
  output logic [JOB_BITS-1:0]                 push_data
);

  localparam int unsigned SUM_BITS = SAMPLE_BITS + COUNT_BITS;

  logic signed [SAMPLE_BITS-1:0] mid_level;
  logic signed [SAMPLE_BITS-1:0] top_level;
  logic [SAMPLE_BITS-1:0]        band_width;
  logic                          was_above;
  logic [TIME_BITS-1:0]          edge_time;
  logic [COUNT_BITS-1:0]         near_count;
  logic signed [SUM_BITS-1:0]    near_sum;

  logic                          accept;
  logic                          above;
  logic                          emit;
  logic signed [SAMPLE_BITS:0]   diff;
  logic [SAMPLE_BITS:0]          gap_mag;
  logic                          near;
  logic [COUNT_BITS-1:0]         count_base;
  logic signed [SUM_BITS-1:0]    sum_base;
  logic                          add;
  logic [COUNT_BITS-1:0]         near_count_next;
  logic signed [SUM_BITS-1:0]    near_sum_next;
  logic [TIME_BITS-1:0]          cycle_length;

  always_comb begin
    in_ready = !q_status.full;
    accept   = in_valid && in_ready;
    above    = sample_value > mid_level;
    // A closed cycle only yields a result when it gathered something.
    emit     = above && !was_above && (near_count != '0);

    diff = {sample_value[SAMPLE_BITS-1], sample_value} - {top_level[SAMPLE_BITS-1], top_level};
    gap_mag = diff[SAMPLE_BITS] ? (SAMPLE_BITS + 1)'(-diff) : diff;
    near    = gap_mag < {1'b0, band_width};

    count_base = emit ? '0 : near_count;
    sum_base   = emit ? '0 : near_sum;
    add        = near && (count_base != '1);

    near_count_next = add ? count_base + 1'b1 : count_base;
    near_sum_next   = add ? sum_base + {{COUNT_BITS{sample_value[SAMPLE_BITS-1]}}, sample_value}
                          : sum_base;

    cycle_length = sample_time - edge_time;
    push         = accept && emit;
    push_data    = {edge_time, cycle_length, near_sum, near_count};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mid_level  <= '0;
      top_level  <= '0;
      band_width <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        ptla_pkg::REG_MID_LEVEL:  mid_level  <= cfg_data;
        ptla_pkg::REG_TOP_LEVEL:  top_level  <= cfg_data;
        ptla_pkg::REG_BAND_WIDTH: band_width <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      was_above  <= 1'b0;
      edge_time  <= '0;
      near_count <= '0;
      near_sum   <= '0;
    end else if (accept) begin
      was_above  <= above;
      if (above && !was_above) begin
        edge_time <= sample_time;
      end
      near_count <= near_count_next;
      near_sum   <= near_sum_next;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/ptla_div.sv
`timescale 1ns / 1ps
`default_nettype none

module ptla_div #(
  parameter int unsigned SAMPLE_BITS = 16,
  parameter int unsigned TIME_BITS   = 48,
  parameter int unsigned COUNT_BITS  = 24,
  parameter int unsigned JOB_BITS    = 2 * TIME_BITS + SAMPLE_BITS + 2 * COUNT_BITS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  ptla_pkg::q_status_t           q_status,
  output logic                          pop,
  input  logic [JOB_BITS-1:0]           pop_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [TIME_BITS-1:0]          cycle_start,
  output logic [TIME_BITS-1:0]          cycle_length,
  output logic signed [SAMPLE_BITS-1:0] top_average
);

  localparam int unsigned SUM_BITS  = SAMPLE_BITS + COUNT_BITS;
  localparam int unsigned STEP_BITS = $clog2(SAMPLE_BITS);

  typedef enum logic [1:0] {
    IDLE,
    RUN,
    HOLD
  } state_t;

  state_t                  state;
  logic [TIME_BITS-1:0]    job_start;
  logic [TIME_BITS-1:0]    job_length;
  logic                    negative;
  logic [COUNT_BITS-1:0]   divisor;
  logic [COUNT_BITS-1:0]   rem;
  logic [SAMPLE_BITS-1:0]  quot;
  logic [STEP_BITS-1:0]    step;

  logic [TIME_BITS-1:0]    in_start;
  logic [TIME_BITS-1:0]    in_length;
  logic signed [SUM_BITS-1:0] in_sum;
  logic [COUNT_BITS-1:0]   in_count;
  logic [SUM_BITS-1:0]     in_mag;
  logic [COUNT_BITS:0]     trial;
  logic [COUNT_BITS:0]     trial_diff;
  logic                    fits;

  always_comb begin
    {in_start, in_length, in_sum, in_count} = pop_data;
    in_mag     = in_sum[SUM_BITS-1] ? SUM_BITS'(-in_sum) : in_sum;
    pop        = (state == IDLE) && !q_status.empty;
    trial      = {rem, quot[SAMPLE_BITS-1]};
    trial_diff = trial - {1'b0, divisor};
    fits       = trial >= {1'b0, divisor};
  end

  // The quotient magnitude never exceeds the largest sample magnitude, so the
  // upper part of the dividend is already below the divisor and only
  // SAMPLE_BITS restoring steps are needed.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        IDLE: begin
          if (pop) begin
            job_start  <= in_start;
            job_length <= in_length;
            negative   <= in_sum[SUM_BITS-1];
            divisor    <= in_count;
            rem        <= in_mag[SUM_BITS-1:SAMPLE_BITS];
            quot       <= in_mag[SAMPLE_BITS-1:0];
            step       <= STEP_BITS'(SAMPLE_BITS - 1);
            state      <= RUN;
          end
        end
        RUN: begin
          rem  <= fits ? trial_diff[COUNT_BITS-1:0] : trial[COUNT_BITS-1:0];
          quot <= {quot[SAMPLE_BITS-2:0], fits};
          step <= step - 1'b1;
          if (step == '0) begin
            state <= HOLD;
          end
        end
        HOLD: begin
          if (!out_valid) begin
            cycle_start  <= job_start;
            cycle_length <= job_length;
            top_average  <= negative ? SAMPLE_BITS'(-quot) : quot;
            out_valid    <= 1'b1;
            state        <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/per_cycle_top_level_averager_unit.sv
// Channel   Handshake              Payload                                      Beat
// cfg       cfg_wr_en              cfg_index, cfg_data                          register write
// in        in_valid / in_ready    sample_value, sample_time                    one sample
// out       out_valid / out_ready  cycle_start, cycle_length, top_average       one closed cycle
//
// The front end takes one sample beat per clock while the job queue has room.
// The serial divider works out one quotient bit per clock and takes a new job
// from the queue only after it has issued the result of the previous one.
// Reset is synchronous and active high; configuration returns to zero and the
// queue empties. When the queue is full, in_ready drops until the divider frees
// an entry; a stalled output beat holds the divider but not the front end.
`timescale 1ns / 1ps
`default_nettype none

module per_cycle_top_level_averager_unit #(
  parameter int unsigned SAMPLE_BITS = 16,
  parameter int unsigned TIME_BITS   = 48,
  parameter int unsigned COUNT_BITS  = 24
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_wr_en,
  input  logic [ptla_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [SAMPLE_BITS-1:0]              cfg_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [SAMPLE_BITS-1:0]       sample_value,
  input  logic [TIME_BITS-1:0]                sample_time,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [TIME_BITS-1:0]                cycle_start,
  output logic [TIME_BITS-1:0]                cycle_length,
  output logic signed [SAMPLE_BITS-1:0]       top_average
);

  // One queued job carries the opening edge time, the cycle length, the
  // running sum and the sample count of a closed cycle.
  localparam int unsigned JOB_BITS = 2 * TIME_BITS + SAMPLE_BITS + 2 * COUNT_BITS;

  ptla_pkg::q_status_t q_status;
  logic                push;
  logic [JOB_BITS-1:0] push_data;
  logic                pop;
  logic [JOB_BITS-1:0] pop_data;

  // The front end detects rising midpoint crossings and accumulates the
  // samples that fall strictly inside the band around the top level.
  ptla_front #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .TIME_BITS   (TIME_BITS),
    .COUNT_BITS  (COUNT_BITS),
    .JOB_BITS    (JOB_BITS)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .sample_value (sample_value),
    .sample_time  (sample_time),
    .q_status     (q_status),
    .push         (push),
    .push_data    (push_data)
  );

  // The queue lets the sample stream run on while a division is in progress.
  ptla_queue #(
    .WIDTH (JOB_BITS),
    .DEPTH (ptla_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .status    (q_status)
  );

  // The back end turns each job into a mean truncated toward zero.
  ptla_div #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .TIME_BITS   (TIME_BITS),
    .COUNT_BITS  (COUNT_BITS),
    .JOB_BITS    (JOB_BITS)
  ) u_div (
    .clk          (clk),
    .rst          (rst),
    .q_status     (q_status),
    .pop          (pop),
    .pop_data     (pop_data),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .cycle_start  (cycle_start),
    .cycle_length (cycle_length),
    .top_average  (top_average)
  );

endmodule

`default_nettype wire

// File: hw/rtl/ptla_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module ptla_checker #(
  parameter int unsigned SAMPLE_BITS = 16,
  parameter int unsigned TIME_BITS   = 48
) (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [TIME_BITS-1:0]          cycle_start,
  input logic [TIME_BITS-1:0]          cycle_length,
  input logic signed [SAMPLE_BITS-1:0] top_average
);

  // Reset empties the output register.
  a_reset_clears_out: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("out_valid high after reset");

  // Reset empties the job queue, so samples are taken straight away.
  a_reset_ready: assert property (@(posedge clk) rst |=> in_ready)
    else $error("in_ready low after reset");

  // A stalled result beat keeps its contents.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(cycle_start)
      && $stable(cycle_length) && $stable(top_average))
    else $error("output beat changed while stalled");

  // Every result needs a full division, so results never come back to back.
  a_out_spacing: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready |=> !out_valid)
    else $error("results issued on consecutive cycles");

endmodule

bind per_cycle_top_level_averager_unit ptla_checker #(
  .SAMPLE_BITS (SAMPLE_BITS),
  .TIME_BITS   (TIME_BITS)
) u_ptla_checker (
  .clk          (clk),
  .rst          (rst),
  .in_ready     (in_ready),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .cycle_start  (cycle_start),
  .cycle_length (cycle_length),
  .top_average  (top_average)
);

`default_nettype wire

// File: bench/per_cycle_top_level_averager_unit_tb.sv
`timescale 1ns / 1ps

// Self-checking bench for the per-cycle top-level averager.
// Sample beats go in on a valid/ready channel. Each accepted beat is folded into
// a model of the block kept here, and every closed waveform cycle that the model
// predicts is queued. Result beats are checked against the oldest queued report.
module per_cycle_top_level_averager_unit_tb;

  localparam int unsigned SAMPLE_BITS = 16;
  localparam int unsigned TIME_BITS   = 48;
  localparam int unsigned COUNT_BITS  = 24;

  // Index 3 names no register, so a write to it must leave everything alone.
  localparam logic [ptla_pkg::CFG_INDEX_BITS-1:0] REG_UNUSED = 2'd3;

  localparam logic [COUNT_BITS-1:0] COUNT_FULL = '1;

  // Room for the queue to drain through the serial divider, with some margin.
  localparam int SETTLE_CYCLES  = (ptla_pkg::QUEUE_DEPTH + 2) * (SAMPLE_BITS + 2);
  localparam int QUIET_LIMIT    = 4000;
  localparam int PHASE_COUNT    = 6;
  localparam int BEATS_PER_PHASE = 75;

  typedef struct packed {
    logic [TIME_BITS-1:0]          start;
    logic [TIME_BITS-1:0]          span;
    logic signed [SAMPLE_BITS-1:0] mean;
  } cycle_report_t;

  localparam cycle_report_t NO_REPORT = '0;

  // A register write, a sample checked by the model alone, or a sample whose
  // closed-cycle report is written out in the table.
  typedef enum logic [1:0] {
    ROW_REG,
    ROW_BEAT,
    ROW_BEAT_TYPED
  } row_kind_t;

  typedef struct packed {
    row_kind_t                           kind;
    logic [ptla_pkg::CFG_INDEX_BITS-1:0] idx;
    logic [SAMPLE_BITS-1:0]              data;
    logic [TIME_BITS-1:0]                stamp;
    cycle_report_t                       want;
  } script_row_t;

  localparam int SCRIPT_LEN = 28;

  // Directed opening. The model starts at mid 0, top 0 and band 0.
  script_row_t script_rows [SCRIPT_LEN] = '{
    // Widest band around the highest top level; the midpoint stays at zero.
    '{ROW_REG,        ptla_pkg::REG_BAND_WIDTH, 16'hFFFF, 48'd0,   NO_REPORT},
    '{ROW_REG,        ptla_pkg::REG_TOP_LEVEL,  16'h7FFF, 48'd0,   NO_REPORT},
    '{ROW_BEAT,       REG_UNUSED,     16'h8001, 48'd5,   NO_REPORT},
    // The most negative code lies exactly one band away and is left out.
    '{ROW_BEAT,       REG_UNUSED,     16'h8000, 48'd15,  NO_REPORT},
    // The first edge after reset opens its cycle at time zero.
    '{ROW_BEAT_TYPED, REG_UNUSED,     16'h7FFF, 48'd25,  '{48'd0, 48'd25, 16'sh8001}},
    // Lowest midpoint: only the most negative code sits at or below it.
    '{ROW_REG,        ptla_pkg::REG_MID_LEVEL,  16'h8000, 48'd0,   NO_REPORT},
    '{ROW_BEAT,       REG_UNUSED,     16'h8000, 48'd35,  NO_REPORT},
    '{ROW_BEAT_TYPED, REG_UNUSED,     16'h8001, 48'd45,  '{48'd25, 48'd20, 16'sh7FFF}},
    '{ROW_BEAT,       REG_UNUSED,     16'h8000, 48'd55,  NO_REPORT},
    '{ROW_BEAT_TYPED, REG_UNUSED,     16'h0001, 48'd65,  '{48'd45, 48'd20, 16'sh8001}},
    // Zero band, and a write to the unused index that must not reach the band.
    '{ROW_REG,        ptla_pkg::REG_BAND_WIDTH, 16'h0000, 48'd0,   NO_REPORT},
    '{ROW_REG,        ptla_pkg::REG_MID_LEVEL,  16'h0000, 48'd0,   NO_REPORT},
    '{ROW_REG,        REG_UNUSED,     16'h7FFF, 48'd0,   NO_REPORT},
    '{ROW_BEAT,       REG_UNUSED,     16'h0000, 48'd75,  NO_REPORT},
    '{ROW_BEAT_TYPED, REG_UNUSED,     16'h0005, 48'd85,  '{48'd65, 48'd20, 16'sh0001}},
    '{ROW_BEAT,       REG_UNUSED,     16'hFFFD, 48'd95,  NO_REPORT},
    // An edge that closes an empty cycle gives no report.
    '{ROW_BEAT,       REG_UNUSED,     16'h0007, 48'd105, NO_REPORT},
    // Lowest top level with a narrow band: the mean of -32768 and -32767 must
    // truncate towards zero.
    '{ROW_REG,        ptla_pkg::REG_TOP_LEVEL,  16'h8000, 48'd0,   NO_REPORT},
    '{ROW_REG,        ptla_pkg::REG_BAND_WIDTH, 16'h0003, 48'd0,   NO_REPORT},
    '{ROW_BEAT,       REG_UNUSED,     16'h8000, 48'd115, NO_REPORT},
    '{ROW_BEAT,       REG_UNUSED,     16'h8001, 48'd125, NO_REPORT},
    '{ROW_BEAT,       REG_UNUSED,     16'h8003, 48'd135, NO_REPORT},
    '{ROW_BEAT_TYPED, REG_UNUSED,     16'h0002, 48'd145, '{48'd105, 48'd40, 16'sh8001}},
    // Time runs backwards, so the cycle length wraps.
    '{ROW_BEAT,       REG_UNUSED,     16'h8000, 48'd155, NO_REPORT},
    '{ROW_BEAT_TYPED, REG_UNUSED,     16'h0003, 48'd6,
      '{48'd145, 48'hFFFF_FFFF_FF75, 16'sh8000}},
    // Timestamps at both ends of their range.
    '{ROW_BEAT,       REG_UNUSED,     16'h8001, 48'hFFFF_FFFF_FFFF, NO_REPORT},
    '{ROW_BEAT,       REG_UNUSED,     16'h0000, 48'd0,   NO_REPORT},
    '{ROW_BEAT,       REG_UNUSED,     16'h7FFF, 48'hFFFF_FFFF_FFFF, NO_REPORT}
  };

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                                cfg_wr_en = 1'b0;
  logic [ptla_pkg::CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [SAMPLE_BITS-1:0]              cfg_data = '0;
  logic                                in_valid = 1'b0;
  logic                                in_ready;
  logic signed [SAMPLE_BITS-1:0]       sample_value = '0;
  logic [TIME_BITS-1:0]                sample_time = '0;
  logic                                out_valid;
  logic                                out_ready = 1'b0;
  logic [TIME_BITS-1:0]                cycle_start;
  logic [TIME_BITS-1:0]                cycle_length;
  logic signed [SAMPLE_BITS-1:0]       top_average;

  // Side band that travels with each sample beat: a report typed into the table.
  logic          beat_typed = 1'b0;
  cycle_report_t beat_want = '0;

  // Model copy of the registers and of the block's running state.
  logic signed [SAMPLE_BITS-1:0]            mid_lvl;
  logic signed [SAMPLE_BITS-1:0]            top_lvl;
  logic [SAMPLE_BITS-1:0]                   band;
  logic                                     prev_above;
  logic [TIME_BITS-1:0]                     open_time;
  logic [COUNT_BITS-1:0]                    near_cnt;
  logic signed [SAMPLE_BITS+COUNT_BITS-1:0] near_acc;

  cycle_report_t        cycle_reports_due [$];
  int                   fail_count = 0;
  int                   quiet_cycles = 0;
  int                   send_idle_pct = 0;
  int                   recv_idle_pct = 0;
  logic [TIME_BITS-1:0] stamp_now = '0;

  per_cycle_top_level_averager_unit #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .TIME_BITS   (TIME_BITS),
    .COUNT_BITS  (COUNT_BITS)
  ) DUT (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .sample_value (sample_value),
    .sample_time  (sample_time),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .cycle_start  (cycle_start),
    .cycle_length (cycle_length),
    .top_average  (top_average)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Folds one sample into the model. Returns 1 when a rising crossing of the
  // midpoint closes a cycle that gathered at least one near-top sample.
  function automatic bit fold_sample(input logic signed [SAMPLE_BITS-1:0] code,
                                     input logic [TIME_BITS-1:0] stamp,
                                     output cycle_report_t rep);
    bit     closed;
    int     gap;
    longint quotient;
    closed = 1'b0;
    rep = NO_REPORT;
    if (code > mid_lvl && !prev_above) begin
      if (near_cnt != 0) begin
        // Signed 64-bit division truncates towards zero, as the block must.
        quotient = longint'(near_acc) / longint'(near_cnt);
        rep.start = open_time;
        rep.span = stamp - open_time;
        rep.mean = quotient[SAMPLE_BITS-1:0];
        closed = 1'b1;
        near_acc = '0;
        near_cnt = '0;
      end
      open_time = stamp;
    end
    gap = int'(code) - int'(top_lvl);
    if (gap < 0) begin
      gap = -gap;
    end
    // Once the count is full, further near-top samples are dropped entirely.
    if (gap < int'(band) && near_cnt != COUNT_FULL) begin
      near_cnt = near_cnt + 1'b1;
      near_acc = near_acc + code;
    end
    prev_above = (code > mid_lvl);
    return closed;
  endfunction

  function automatic logic [SAMPLE_BITS-1:0] to_code(input int level);
    if (level > 32767) begin
      level = 32767;
    end else if (level < -32768) begin
      level = -32768;
    end
    return level[SAMPLE_BITS-1:0];
  endfunction

  // Timestamps mostly creep forwards; now and then they jump anywhere at all,
  // which also runs them backwards and sets every bit.
  function automatic logic [TIME_BITS-1:0] next_stamp();
    if ($urandom_range(99) < 3) begin
      stamp_now = TIME_BITS'({$urandom, $urandom});
    end else begin
      stamp_now = stamp_now + $urandom_range(1, 40);
    end
    return stamp_now;
  endfunction

  task automatic flag_field(input string field, input logic [TIME_BITS-1:0] want,
                            input logic [TIME_BITS-1:0] got);
    $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
    fail_count++;
  endtask

  // The receiver holds ready low in the given share of cycles.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // One process samples every channel at the clock edge, so the order in which
  // the beats of one edge are handled is fixed: results are checked, register
  // writes applied, then the accepted sample is folded into the model.
  always @(posedge clk) begin
    cycle_report_t rep;
    cycle_report_t want;
    if (rst) begin
      mid_lvl = '0;
      top_lvl = '0;
      band = '0;
      prev_above = 1'b0;
      open_time = '0;
      near_cnt = '0;
      near_acc = '0;
      quiet_cycles = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (cycle_reports_due.size() == 0) begin
          $display("%0t: expected no result, actual start %0h length %0h mean %0d",
                   $time, cycle_start, cycle_length, top_average);
          fail_count++;
        end else begin
          want = cycle_reports_due.pop_front();
          if (cycle_start !== want.start) begin
            flag_field("cycle_start", want.start, cycle_start);
          end
          if (cycle_length !== want.span) begin
            flag_field("cycle_length", want.span, cycle_length);
          end
          if (top_average !== want.mean) begin
            flag_field("top_average", TIME_BITS'(want.mean), TIME_BITS'(top_average));
          end
        end
      end
      if (cfg_wr_en) begin
        case (cfg_index)
          ptla_pkg::REG_MID_LEVEL:  mid_lvl = cfg_data;
          ptla_pkg::REG_TOP_LEVEL:  top_lvl = cfg_data;
          ptla_pkg::REG_BAND_WIDTH: band = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        if (fold_sample(sample_value, sample_time, rep) && !beat_typed) begin
          cycle_reports_due.insert(cycle_reports_due.size(), rep);
        end
        if (beat_typed) begin
          cycle_reports_due.insert(cycle_reports_due.size(), beat_want);
        end
      end
      // The watchdog only counts cycles in which neither data channel moves.
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("%0t: no beat moved for %0d cycles", $time, QUIET_LIMIT);
        $display("FAIL per_cycle_top_level_averager_unit");
        $finish;
      end
    end
  end

  // Offers one sample beat after a random gap and returns at the edge that
  // accepts it. Valid is left high, so back-to-back beats never toggle it.
  task automatic send_beat(input logic [SAMPLE_BITS-1:0] code,
                           input logic [TIME_BITS-1:0] stamp,
                           input logic typed, input cycle_report_t want);
    cfg_wr_en <= 1'b0;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    sample_value <= code;
    sample_time <= stamp;
    beat_typed <= typed;
    beat_want <= want;
    do begin
      @(posedge clk);
    end while (!in_ready);
  endtask

  // The sender stops until every report has arrived, then waits out the
  // divider, so that the block is quiet before registers change.
  task automatic drain_and_settle();
    in_valid <= 1'b0;
    while (cycle_reports_due.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [ptla_pkg::CFG_INDEX_BITS-1:0] idx,
                           input logic [SAMPLE_BITS-1:0] data);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
  endtask

  initial begin
    bit busy;
    int mid_cfg;
    int top_cfg;
    int band_cfg;
    int reach;
    int sent;
    busy = 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed table, with the sender at 34 % idle and the receiver at 71 %.
    send_idle_pct = 34;
    recv_idle_pct = 71;
    for (int r = 0; r < SCRIPT_LEN; r++) begin
      if (script_rows[r].kind == ROW_REG) begin
        if (busy) begin
          drain_and_settle();
          busy = 1'b0;
        end
        write_reg(script_rows[r].idx, script_rows[r].data);
      end else begin
        send_beat(script_rows[r].data, script_rows[r].stamp,
                  script_rows[r].kind == ROW_BEAT_TYPED, script_rows[r].want);
        busy = 1'b1;
      end
    end

    // Random phases: two with the sender idling less than the receiver, two
    // the other way round, and two in which neither side ever idles. Each phase
    // starts from a drained block and a fresh register setting.
    stamp_now = 48'd1000;
    for (int p = 0; p < PHASE_COUNT; p++) begin
      drain_and_settle();
      if (p < 2) begin
        send_idle_pct = 34;
        recv_idle_pct = 71;
      end else if (p < 4) begin
        send_idle_pct = 71;
        recv_idle_pct = 34;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      mid_cfg = int'($urandom_range(40000)) - 20000;
      top_cfg = mid_cfg + int'($urandom_range(1, 12000));
      band_cfg = int'($urandom_range(1, 4000));
      if (p == 3) begin
        // Band of one: only samples exactly at the top level are averaged.
        band_cfg = 1;
      end else if (p == 5) begin
        // Every register at its extreme.
        mid_cfg = -32768;
        top_cfg = 32767;
        band_cfg = 65535;
      end
      write_reg(ptla_pkg::REG_MID_LEVEL, to_code(mid_cfg));
      write_reg(ptla_pkg::REG_TOP_LEVEL, to_code(top_cfg));
      write_reg(ptla_pkg::REG_BAND_WIDTH, band_cfg[SAMPLE_BITS-1:0]);
      reach = (band_cfg > 4000) ? 4000 : band_cfg;
      sent = 0;
      while (sent < BEATS_PER_PHASE) begin
        if ($urandom_range(99) < 12) begin
          // Noise: any code at all.
          send_beat(SAMPLE_BITS'($urandom), next_stamp(), 1'b0, NO_REPORT);
          sent++;
        end else begin
          // One waveform period: a low stretch at or below the midpoint, then
          // a high stretch scattered around the top level.
          repeat ($urandom_range(1, 5)) begin
            send_beat(to_code(mid_cfg - int'($urandom_range(3000))), next_stamp(),
                      1'b0, NO_REPORT);
            sent++;
          end
          repeat ($urandom_range(1, 8)) begin
            send_beat(to_code(top_cfg + int'($urandom_range(2 * reach)) - reach),
                      next_stamp(), 1'b0, NO_REPORT);
            sent++;
          end
        end
      end
    end

    drain_and_settle();
    if (fail_count == 0) begin
      $display("PASS per_cycle_top_level_averager_unit");
    end else begin
      $display("FAIL per_cycle_top_level_averager_unit");
    end
    $finish;
  end

endmodule

// File: files.f
hw/rtl/ptla_pkg.sv
hw/rtl/ptla_queue.sv
hw/rtl/ptla_front.sv
hw/rtl/ptla_div.sv
hw/rtl/per_cycle_top_level_averager_unit.sv
hw/rtl/ptla_checker.sv
bench/per_cycle_top_level_averager_unit_tb.sv
